[design/linked_cell_list_binning_unit_defines.svh]
// assertion macros shared by the checker of the cell binning unit
// expects signals named clk and rst in the scope of use
`ifndef LINKED_CELL_LIST_BINNING_UNIT_DEFINES_SVH
`define LINKED_CELL_LIST_BINNING_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is high
`define LCLB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is high
`define LCLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// same-cycle implication that also holds through reset
`define LCLB_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

[design/lclb_pkg.sv]
// shared types and constants of the cell binning unit
// no dependencies
`timescale 1ns / 1ps

package lclb_pkg;

  // field widths
  localparam int MOL_W   = 12;
  localparam int POS_W   = 24;
  localparam int CNT_W   = 5;
  localparam int LEN_W   = 24;
  localparam int CELL_W  = 12;
  localparam int OCC_W   = 13;

  // configuration port
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_LEN_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_LEN_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_LEN_Z = 3'd5;

  // register reset values
  localparam logic [CNT_W-1:0] CELLS_RESET   = 5'd1;
  localparam logic [LEN_W-1:0] CELL_LEN_RESET = 24'd256;

  // head entry that marks an empty cell
  localparam logic [OCC_W-1:0] EMPTY = 13'd4096;

  // one quotient bit per divider step
  localparam int DIV_STEPS = POS_W;

  // parameter defaults
  localparam int DEF_MAX_CELLS_PER_AXIS = 16;
  localparam int DEF_MAX_MOLECULES      = 4096;

  // divider control
  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

[design/lclb_item_if.sv]
// input channel of the cell binning unit: molecule index and position
// depends on lclb_pkg
`timescale 1ns / 1ps

interface lclb_item_if;
  logic                        valid;
  logic                        ready;
  logic [lclb_pkg::MOL_W-1:0]  molecule_index;
  logic [lclb_pkg::POS_W-1:0]  pos_x;
  logic [lclb_pkg::POS_W-1:0]  pos_y;
  logic [lclb_pkg::POS_W-1:0]  pos_z;

  modport source (output valid, output molecule_index, output pos_x, output pos_y,
                  output pos_z, input ready);
  modport sink (input valid, input molecule_index, input pos_x, input pos_y,
                input pos_z, output ready);
endinterface

[design/lclb_result_if.sv]
// output channel of the cell binning unit: cell index and former head
// depends on lclb_pkg
`timescale 1ns / 1ps

interface lclb_result_if;
  logic                        valid;
  logic                        ready;
  logic [lclb_pkg::CELL_W-1:0] cell_index;
  logic [lclb_pkg::OCC_W-1:0]  previous_occupant;

  modport source (output valid, output cell_index, output previous_occupant,
                  input ready);
  modport sink (input valid, input cell_index, input previous_occupant,
                output ready);
endinterface

[design/linked_cell_list_binning_unit.sv]
// Cell binning unit: places molecules into a 3-D grid of cells and pushes each
// onto the front of its cell's linked list.
// item channel (valid/ready): molecule_index and pos_x/y/z. result channel
// (valid/ready): cell_index and previous_occupant (4096 when the cell was empty).
// Configuration is a write port (wr_en, wr_index, wr_data) for cell counts and
// cell lengths; the user must write it only while no item is in flight, as the
// block does not enforce this. One item at a time: a beat is accepted, three
// radix-2 dividers run 24 steps in parallel (one quotient bit per cycle), then
// clamp, two multiply stages, a head table read and the push. The result becomes
// valid in the same cycle as the block returns to idle and can take the next
// item; the divider's 24 steps take most of the time per item.
// The result sits in an output register, so the next item is accepted while an
// earlier result still waits; a stalled receiver holds the block only when a new
// result is ready to enter that register.
// Reset: registers go to count 1 and length 1.0, then the head table, with
// MAX_CELLS_PER_AXIS^3 entries (4096 by default), is swept to empty, one entry
// per cycle; no item is accepted during the sweep. The link table needs no clearing.
// depends on lclb_pkg, lclb_item_if, lclb_result_if, lclb_ram, lclb_div
`timescale 1ns / 1ps

module linked_cell_list_binning_unit #(
  parameter int MAX_CELLS_PER_AXIS = lclb_pkg::DEF_MAX_CELLS_PER_AXIS,
  parameter int MAX_MOLECULES      = lclb_pkg::DEF_MAX_MOLECULES
) (
  input  logic                           clk,
  input  logic                           rst,
  lclb_item_if.sink                      item,
  lclb_result_if.source                  result,
  input  logic                           wr_en,
  input  logic [lclb_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [lclb_pkg::CFG_W-1:0]     wr_data
);

  localparam int NUM_CELLS = MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS;
  localparam int HEAD_AW   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int LINK_DEPTH = (MAX_MOLECULES < (1 << lclb_pkg::MOL_W)) ?
                              MAX_MOLECULES : (1 << lclb_pkg::MOL_W);
  localparam int LINK_AW   = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
  localparam int EC_W      = $clog2(MAX_CELLS_PER_AXIS + 1);
  localparam int AXIS_W    = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1;
  localparam int T_W       = 2 * EC_W;
  localparam int C_W       = 3 * EC_W;
  localparam int STEP_W    = $clog2(lclb_pkg::DIV_STEPS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_CLAMP = 3'd3;
  localparam logic [2:0] S_MUL1  = 3'd4;
  localparam logic [2:0] S_MUL2  = 3'd5;
  localparam logic [2:0] S_READ  = 3'd6;
  localparam logic [2:0] S_PUSH  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  // configuration registers
  logic [lclb_pkg::CNT_W-1:0] cells_x;
  logic [lclb_pkg::CNT_W-1:0] cells_y;
  logic [lclb_pkg::CNT_W-1:0] cells_z;
  logic [lclb_pkg::LEN_W-1:0] cell_len_x;
  logic [lclb_pkg::LEN_W-1:0] cell_len_y;
  logic [lclb_pkg::LEN_W-1:0] cell_len_z;

  logic [EC_W-1:0]             cnt_x;
  logic [EC_W-1:0]             cnt_y;
  logic [EC_W-1:0]             cnt_z;
  logic [lclb_pkg::MOL_W-1:0]  mol;
  logic                        mol_ok;
  logic [STEP_W-1:0]           step_cnt;
  logic [HEAD_AW-1:0]          clr_cnt;
  lclb_pkg::div_ctrl_t         div_ctrl;
  logic [lclb_pkg::POS_W-1:0]  quo_x;
  logic [lclb_pkg::POS_W-1:0]  quo_y;
  logic [lclb_pkg::POS_W-1:0]  quo_z;
  logic [AXIS_W-1:0]           vx;
  logic [AXIS_W-1:0]           vy;
  logic [AXIS_W-1:0]           vz;
  logic [T_W-1:0]              row;
  logic [HEAD_AW-1:0]          cell_addr;
  logic                        slot_free;
  logic                        push;

  logic                        head_we;
  logic [HEAD_AW-1:0]          head_waddr;
  logic [lclb_pkg::OCC_W-1:0]  head_wdata;
  logic [lclb_pkg::OCC_W-1:0]  head_rdata;

  logic                        out_valid;
  logic [lclb_pkg::CELL_W-1:0] out_cell;
  logic [lclb_pkg::OCC_W-1:0]  out_prev;

  // effective cell count: zero acts as one, clamp at the grid maximum
  function automatic logic [EC_W-1:0] eff_count(input logic [lclb_pkg::CNT_W-1:0] n);
    logic [EC_W-1:0] r;
    if (n == '0) begin
      r = EC_W'(1);
    end else if (32'(n) > 32'(MAX_CELLS_PER_AXIS)) begin
      r = EC_W'(MAX_CELLS_PER_AXIS);
    end else begin
      r = EC_W'(n);
    end
    return r;
  endfunction

  // saturate a quotient at count minus one
  function automatic logic [AXIS_W-1:0] clamp_axis(input logic [lclb_pkg::POS_W-1:0] q,
                                                   input logic [EC_W-1:0] cnt);
    logic [EC_W-1:0] top;
    top = cnt - EC_W'(1);
    return (q > lclb_pkg::POS_W'(top)) ? AXIS_W'(top) : AXIS_W'(q);
  endfunction

  assign cnt_x = eff_count(cells_x);
  assign cnt_y = eff_count(cells_y);
  assign cnt_z = eff_count(cells_z);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cells_x    <= lclb_pkg::CELLS_RESET;
      cells_y    <= lclb_pkg::CELLS_RESET;
      cells_z    <= lclb_pkg::CELLS_RESET;
      cell_len_x <= lclb_pkg::CELL_LEN_RESET;
      cell_len_y <= lclb_pkg::CELL_LEN_RESET;
      cell_len_z <= lclb_pkg::CELL_LEN_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        lclb_pkg::REG_CELLS_X:    cells_x    <= wr_data[lclb_pkg::CNT_W-1:0];
        lclb_pkg::REG_CELLS_Y:    cells_y    <= wr_data[lclb_pkg::CNT_W-1:0];
        lclb_pkg::REG_CELLS_Z:    cells_z    <= wr_data[lclb_pkg::CNT_W-1:0];
        lclb_pkg::REG_CELL_LEN_X: cell_len_x <= wr_data[lclb_pkg::LEN_W-1:0];
        lclb_pkg::REG_CELL_LEN_Y: cell_len_y <= wr_data[lclb_pkg::LEN_W-1:0];
        lclb_pkg::REG_CELL_LEN_Z: cell_len_z <= wr_data[lclb_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake and push condition
  assign item.ready = (state == S_IDLE);
  assign slot_free  = !out_valid || result.ready;
  assign push       = (state == S_PUSH) && slot_free;
  assign mol_ok     = (32'(mol) < 32'(MAX_MOLECULES));

  // divider control
  always_comb begin
    div_ctrl.load = item.valid && item.ready;
    div_ctrl.step = (state == S_DIV);
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_cnt == HEAD_AW'(NUM_CELLS - 1)) state_next = S_IDLE;
      S_IDLE:  if (item.valid) state_next = S_DIV;
      S_DIV:   if (step_cnt == STEP_W'(lclb_pkg::DIV_STEPS - 1)) state_next = S_CLAMP;
      S_CLAMP: state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_READ;
      S_READ:  state_next = S_PUSH;
      S_PUSH:  if (slot_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + HEAD_AW'(1);
      end
      if (state == S_DIV) begin
        step_cnt <= step_cnt + STEP_W'(1);
      end else begin
        step_cnt <= '0;
      end
    end
  end

  // one divider per axis
  lclb_div u_div_x (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (item.pos_x),
    .divisor  (cell_len_x),
    .quotient (quo_x)
  );

  lclb_div u_div_y (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (item.pos_y),
    .divisor  (cell_len_y),
    .quotient (quo_y)
  );

  lclb_div u_div_z (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (item.pos_z),
    .divisor  (cell_len_z),
    .quotient (quo_z)
  );

  // molecule capture, clamp and flattening stages
  always_ff @(posedge clk) begin
    if (div_ctrl.load) begin
      mol <= item.molecule_index;
    end
    if (state == S_CLAMP) begin
      vx <= clamp_axis(quo_x, cnt_x);
      vy <= clamp_axis(quo_y, cnt_y);
      vz <= clamp_axis(quo_z, cnt_z);
    end
    if (state == S_MUL1) begin
      row <= T_W'(vx) * T_W'(cnt_y) + T_W'(vy);
    end
    if (state == S_MUL2) begin
      cell_addr <= HEAD_AW'(C_W'(row) * C_W'(cnt_z) + C_W'(vz));
    end
  end

  // head table: sweep on clear, push on the final stage
  always_comb begin
    if (state == S_CLEAR) begin
      head_we    = 1'b1;
      head_waddr = clr_cnt;
      head_wdata = lclb_pkg::EMPTY;
    end else begin
      head_we    = push && mol_ok;
      head_waddr = cell_addr;
      head_wdata = {1'b0, mol};
    end
  end

  lclb_ram #(
    .WIDTH (lclb_pkg::OCC_W),
    .DEPTH (NUM_CELLS)
  ) u_head_ram (
    .clk     (clk),
    .wr_en   (head_we),
    .wr_addr (head_waddr),
    .wr_data (head_wdata),
    .rd_addr (cell_addr),
    .rd_data (head_rdata)
  );

  // link table takes the former head
  lclb_ram #(
    .WIDTH (lclb_pkg::OCC_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (push && mol_ok),
    .wr_addr (mol[LINK_AW-1:0]),
    .wr_data (head_rdata),
    .rd_addr (mol[LINK_AW-1:0]),
    .rd_data ()
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_cell <= lclb_pkg::CELL_W'(cell_addr);
      out_prev <= head_rdata;
    end
  end

  assign result.valid             = out_valid;
  assign result.cell_index        = out_cell;
  assign result.previous_occupant = out_prev;

endmodule

[design/lclb_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module lclb_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[design/lclb_div.sv]
// radix-2 restoring divider, one quotient bit per step, for one axis
// depends on lclb_pkg; a zero divisor gives an all-ones quotient
`timescale 1ns / 1ps

module lclb_div (
  input  logic                       clk,
  input  lclb_pkg::div_ctrl_t        ctrl,
  input  logic [lclb_pkg::POS_W-1:0] dividend,
  input  logic [lclb_pkg::LEN_W-1:0] divisor,
  output logic [lclb_pkg::POS_W-1:0] quotient
);

  logic [lclb_pkg::LEN_W-1:0] rem;
  logic [lclb_pkg::POS_W-1:0] dvd;
  logic [lclb_pkg::LEN_W-1:0] dvsr;
  logic [lclb_pkg::POS_W-1:0] quo;
  logic [lclb_pkg::LEN_W:0]   rem_sh;
  logic [lclb_pkg::LEN_W+1:0] diff;
  logic                       qbit;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    rem_sh = {rem, dvd[lclb_pkg::POS_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvsr};
    qbit   = ~diff[lclb_pkg::LEN_W+1];
  end

  // shift registers: dividend out, quotient in
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem  <= '0;
      dvd  <= dividend;
      dvsr <= divisor;
      quo  <= '0;
    end else if (ctrl.step) begin
      rem  <= qbit ? diff[lclb_pkg::LEN_W-1:0] : rem_sh[lclb_pkg::LEN_W-1:0];
      dvd  <= {dvd[lclb_pkg::POS_W-2:0], 1'b0};
      quo  <= {quo[lclb_pkg::POS_W-2:0], qbit};
    end
  end

  assign quotient = quo;

endmodule

[design/lclb_checker.sv]
// port-level checks of the cell binning unit, bound to the top level
// depends on lclb_pkg and the assertion macros header
`timescale 1ns / 1ps
`include "linked_cell_list_binning_unit_defines.svh"

module lclb_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_ready,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic [lclb_pkg::CELL_W-1:0] cell_index,
  input logic [lclb_pkg::OCC_W-1:0]  previous_occupant
);

  logic [1:0] pending;
  logic       item_beat;
  logic       result_beat;

  assign item_beat   = item_valid && item_ready;
  assign result_beat = result_valid && result_ready;

  // items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(item_beat) - 2'(result_beat);
    end
  end

  `LCLB_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(cell_index) && $stable(previous_occupant), "stalled result changed")
  `LCLB_ASSERT_NOW(a_no_spurious, result_valid, pending != 2'd0, "result without a pending item")
  `LCLB_ASSERT_NOW(a_one_in_work, item_beat, pending == 2'd0 || pending == 2'd1, "item taken while another is at work")
  `LCLB_ASSERT_NOW(a_occ_range, result_valid, previous_occupant <= lclb_pkg::EMPTY, "former head out of range")
  `LCLB_ASSERT_ALWAYS(a_clear_after_rst, $past(rst), !item_ready, "item taken during head sweep")

endmodule

bind linked_cell_list_binning_unit lclb_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .item_valid        (item.valid),
  .item_ready        (item.ready),
  .result_valid      (result.valid),
  .result_ready      (result.ready),
  .cell_index        (result.cell_index),
  .previous_occupant (result.previous_occupant)
);

[sim/linked_cell_list_binning_unit_tb.sv]
// testbench for the cell binning unit: directed and random molecule placement
// checked against a local model of the cell grid and head table
// depends on lclb_pkg, lclb_item_if, lclb_result_if, linked_cell_list_binning_unit
`timescale 1ns / 1ps

module linked_cell_list_binning_unit_tb;

  localparam int NUM_CELLS  = lclb_pkg::DEF_MAX_CELLS_PER_AXIS ** 3;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 40;

  typedef struct packed {
    logic [lclb_pkg::CELL_W-1:0] cell_idx;
    logic [lclb_pkg::OCC_W-1:0]  occupant;
  } bin_t;

  logic                           clk;
  logic                           rst;
  logic                           wr_en;
  logic [lclb_pkg::CFG_IDX_W-1:0] wr_index;
  logic [lclb_pkg::CFG_W-1:0]     wr_data;

  lclb_item_if   item_ch ();
  lclb_result_if result_ch ();

  linked_cell_list_binning_unit dut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (result_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // local copy of the grid registers and the head table
  logic [lclb_pkg::CNT_W-1:0] grid_cnt_x, grid_cnt_y, grid_cnt_z;
  logic [lclb_pkg::LEN_W-1:0] grid_len_x, grid_len_y, grid_len_z;
  logic [lclb_pkg::OCC_W-1:0] head_of_cell [NUM_CELLS];

  bin_t pending_bins[$];
  bin_t want;
  int   mismatches;
  int   idle_cycles;
  int   items_sent;
  bit   tx_steady;
  bit   rx_steady;
  int   hold_off_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // effective cell count along one axis
  function automatic int unsigned grid_extent(logic [lclb_pkg::CNT_W-1:0] n);
    if (n == 0) return 1;
    if (32'(n) > lclb_pkg::DEF_MAX_CELLS_PER_AXIS) return lclb_pkg::DEF_MAX_CELLS_PER_AXIS;
    return 32'(n);
  endfunction

  // truncated quotient, saturated at the last cell
  function automatic int unsigned cell_coord(logic [lclb_pkg::POS_W-1:0] pos,
                                             logic [lclb_pkg::LEN_W-1:0] len,
                                             int unsigned extent);
    int unsigned q;
    if (len == 0) q = 32'hFFFFFF;
    else q = int'(pos) / int'(len);
    if (q > extent - 1) q = extent - 1;
    return q;
  endfunction

  // push one molecule onto its cell list and record the expected result
  task automatic bin_molecule(logic [lclb_pkg::MOL_W-1:0] mol, logic [lclb_pkg::POS_W-1:0] px,
                              logic [lclb_pkg::POS_W-1:0] py, logic [lclb_pkg::POS_W-1:0] pz);
    int unsigned cx, cy, cz, c;
    bin_t r;
    cx = grid_extent(grid_cnt_x);
    cy = grid_extent(grid_cnt_y);
    cz = grid_extent(grid_cnt_z);
    c  = (cell_coord(px, grid_len_x, cx) * cy + cell_coord(py, grid_len_y, cy)) * cz
         + cell_coord(pz, grid_len_z, cz);
    if (c >= NUM_CELLS) c = NUM_CELLS - 1;
    r.cell_idx = c[lclb_pkg::CELL_W-1:0];
    r.occupant = head_of_cell[c];
    if (int'(mol) < lclb_pkg::DEF_MAX_MOLECULES) head_of_cell[c] = {1'b0, mol};
    pending_bins.push_back(r);
  endtask

  function automatic int draw_gap(bit steady);
    if (steady) return 0;
    return $urandom_range(0, 3);
  endfunction

  // send one item beat; valid stays high unless the next call draws a gap
  task automatic send_item(logic [lclb_pkg::MOL_W-1:0] mol, logic [lclb_pkg::POS_W-1:0] px,
                           logic [lclb_pkg::POS_W-1:0] py, logic [lclb_pkg::POS_W-1:0] pz);
    int gap;
    gap = draw_gap(tx_steady);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid          <= 1'b1;
    item_ch.molecule_index <= mol;
    item_ch.pos_x          <= px;
    item_ch.pos_y          <= py;
    item_ch.pos_z          <= pz;
    do @(posedge clk); while (!item_ch.ready);
    bin_molecule(mol, px, py, pz);
    items_sent++;
  endtask

  // stop offering items and wait for every outstanding result
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [lclb_pkg::CFG_IDX_W-1:0] idx,
                           logic [lclb_pkg::CFG_W-1:0] value);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(posedge clk);
    case (idx)
      lclb_pkg::REG_CELLS_X:    grid_cnt_x = value[lclb_pkg::CNT_W-1:0];
      lclb_pkg::REG_CELLS_Y:    grid_cnt_y = value[lclb_pkg::CNT_W-1:0];
      lclb_pkg::REG_CELLS_Z:    grid_cnt_z = value[lclb_pkg::CNT_W-1:0];
      lclb_pkg::REG_CELL_LEN_X: grid_len_x = value[lclb_pkg::LEN_W-1:0];
      lclb_pkg::REG_CELL_LEN_Y: grid_len_y = value[lclb_pkg::LEN_W-1:0];
      lclb_pkg::REG_CELL_LEN_Z: grid_len_z = value[lclb_pkg::LEN_W-1:0];
      default: ;
    endcase
  endtask

  // write all six grid registers back to back; block must be idle
  task automatic load_grid(logic [lclb_pkg::CFG_W-1:0] nx, logic [lclb_pkg::CFG_W-1:0] ny,
                           logic [lclb_pkg::CFG_W-1:0] nz, logic [lclb_pkg::CFG_W-1:0] lx,
                           logic [lclb_pkg::CFG_W-1:0] ly, logic [lclb_pkg::CFG_W-1:0] lz);
    write_reg(lclb_pkg::REG_CELLS_X, nx);
    write_reg(lclb_pkg::REG_CELLS_Y, ny);
    write_reg(lclb_pkg::REG_CELLS_Z, nz);
    write_reg(lclb_pkg::REG_CELL_LEN_X, lx);
    write_reg(lclb_pkg::REG_CELL_LEN_Y, ly);
    write_reg(lclb_pkg::REG_CELL_LEN_Z, lz);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // coordinate mostly inside the box, sometimes on a cell edge or anywhere
  function automatic logic [lclb_pkg::POS_W-1:0] pick_coord(logic [lclb_pkg::LEN_W-1:0] len,
                                                            logic [lclb_pkg::CNT_W-1:0] cnt);
    int unsigned span, roll, k, v;
    span = int'(len) * grid_extent(cnt);
    roll = $urandom_range(0, 99);
    if (len == 0 || roll < 15) return lclb_pkg::POS_W'($urandom());
    if (roll < 35) begin
      k = $urandom_range(0, grid_extent(cnt));
      v = int'(len) * k;
      if (roll < 25 && v > 0) v = v - 1;
    end else begin
      v = $urandom_range(0, span + int'(len) / 2);
    end
    if (v > 32'hFFFFFF) v = 32'hFFFFFF;
    return v[lclb_pkg::POS_W-1:0];
  endfunction

  function automatic logic [lclb_pkg::MOL_W-1:0] pick_molecule();
    if ($urandom_range(0, 1) == 0) return lclb_pkg::MOL_W'($urandom_range(0, 15));
    return lclb_pkg::MOL_W'($urandom());
  endfunction

  task automatic send_random_item();
    send_item(pick_molecule(), pick_coord(grid_len_x, grid_cnt_x),
              pick_coord(grid_len_y, grid_cnt_y), pick_coord(grid_len_z, grid_cnt_z));
  endtask

  function automatic logic [lclb_pkg::CFG_W-1:0] pick_count();
    logic [lclb_pkg::CFG_W-1:0] v;
    if ($urandom_range(0, 4) != 0) begin
      v = lclb_pkg::CFG_W'($urandom_range(1, lclb_pkg::DEF_MAX_CELLS_PER_AXIS));
    end else begin
      v = lclb_pkg::CFG_W'($urandom_range(0, 31));
    end
    // junk in the unused upper bits now and then
    if ($urandom_range(0, 9) == 0) v = v | (lclb_pkg::CFG_W'($urandom()) & 24'hFFFFE0);
    return v;
  endfunction

  function automatic logic [lclb_pkg::CFG_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 24'hFFFFFF;
      2:       return lclb_pkg::CFG_W'($urandom_range(1, 255));
      3:       return lclb_pkg::CFG_W'($urandom());
      default: return lclb_pkg::CFG_W'(256 * $urandom_range(1, 64));
    endcase
  endfunction

  // receiver: random stalls, steady stretches and one long hold-off on request
  initial begin
    int wait_n;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        wait_n = hold_off_cycles;
        hold_off_cycles = 0;
        result_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end else begin
        wait_n = draw_gap(rx_steady);
        if (wait_n > 0) begin
          result_ch.ready <= 1'b0;
          repeat (wait_n) @(posedge clk);
        end
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  // result checker: each beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_bins.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat: cell_index %0d previous_occupant %0d",
                 $time, result_ch.cell_index, result_ch.previous_occupant);
      end else begin
        want = pending_bins.pop_front();
        if (result_ch.cell_index !== want.cell_idx) begin
          mismatches++;
          $display("%0t: cell_index mismatch: expected %0d, actual %0d",
                   $time, want.cell_idx, result_ch.cell_index);
        end
        if (result_ch.previous_occupant !== want.occupant) begin
          mismatches++;
          $display("%0t: previous_occupant mismatch: expected %0d, actual %0d",
                   $time, want.occupant, result_ch.previous_occupant);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("linked_cell_list_binning_unit_tb: errors");
        $finish;
      end
    end
  end

  // reset values: every molecule lands in cell zero
  task automatic test_reset_defaults();
    send_item(12'd0, 24'd0, 24'd0, 24'd0);
    send_item(12'hFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_item(12'hAAA, 24'h555555, 24'hAAAAAA, 24'h000100);
    send_item(12'h555, 24'hAAAAAA, 24'h555555, 24'h0000FF);
    wait_idle();
  endtask

  // full 16x16x16 grid: corners, cell edges, beyond the box, repeated molecule
  task automatic test_full_grid();
    load_grid(16, 16, 16, 256, 256, 256);
    send_item(12'd1, 24'd0, 24'd0, 24'd0);
    send_item(12'd2, 24'd4095, 24'd4095, 24'd4095);
    send_item(12'd3, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_item(12'd4, 24'd256, 24'd512, 24'd768);
    send_item(12'd5, 24'd255, 24'd256, 24'd257);
    send_item(12'd1, 24'd0, 24'd0, 24'd0);
    send_item(12'd6, 24'd3840, 24'd0, 24'd0);
    wait_idle();
  endtask

  // zero count, counts above the maximum, zero and extreme cell lengths
  task automatic test_special_counts();
    load_grid(0, 31, 24'hFFFFF1, 0, 24'hFFFFFF, 1);
    send_item(12'd7, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_item(12'd8, 24'd0, 24'd0, 24'd0);
    send_item(12'd9, 24'd0, 24'd0, 24'd5);
    send_item(12'd10, 24'h123456, 24'hFFFFFE, 24'd14);
    send_item(12'd11, 24'h800000, 24'd1, 24'd15);
    wait_idle();
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_receiver_hold();
    load_grid(4, 4, 4, 512, 512, 512);
    tx_steady = 1'b1;
    rx_steady = 1'b0;
    hold_off_cycles = 400;
    repeat (30) send_random_item();
    tx_steady = 1'b0;
    wait_idle();
  endtask

  // random grid settings, each phase drained before the next write
  task automatic test_random_phases();
    int n;
    while (items_sent < 700) begin
      load_grid(pick_count(), pick_count(), pick_count(),
                pick_length(), pick_length(), pick_length());
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(30, 80);
      repeat (n) send_random_item();
      wait_idle();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    mismatches      = 0;
    items_sent      = 0;
    tx_steady       = 1'b0;
    rx_steady       = 1'b0;
    hold_off_cycles = 0;
    grid_cnt_x = lclb_pkg::CELLS_RESET;
    grid_cnt_y = lclb_pkg::CELLS_RESET;
    grid_cnt_z = lclb_pkg::CELLS_RESET;
    grid_len_x = lclb_pkg::CELL_LEN_RESET;
    grid_len_y = lclb_pkg::CELL_LEN_RESET;
    grid_len_z = lclb_pkg::CELL_LEN_RESET;
    for (int i = 0; i < NUM_CELLS; i++) head_of_cell[i] = lclb_pkg::EMPTY;

    rst                    <= 1'b1;
    wr_en                  <= 1'b0;
    wr_index               <= '0;
    wr_data                <= '0;
    item_ch.valid          <= 1'b0;
    item_ch.molecule_index <= '0;
    item_ch.pos_x          <= '0;
    item_ch.pos_y          <= '0;
    item_ch.pos_z          <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_full_grid();
    test_special_counts();
    test_receiver_hold();
    test_random_phases();

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_bins.size() == 0) begin
      $display("linked_cell_list_binning_unit_tb: clean");
    end else begin
      $display("linked_cell_list_binning_unit_tb: errors");
    end
    $finish;
  end

endmodule

[linked_cell_list_binning_unit.f]
+incdir+design
design/lclb_pkg.sv
design/lclb_item_if.sv
design/lclb_result_if.sv
design/lclb_ram.sv
design/lclb_div.sv
design/linked_cell_list_binning_unit.sv
design/lclb_checker.sv
sim/linked_cell_list_binning_unit_tb.sv
